// File: rtl/core/lsmal_pkg.sv
// ----------------------------------------------------------------------------
// lsmal_pkg
// Shared types and constants of the longest-segment-mean block.
// ----------------------------------------------------------------------------
package lsmal_pkg;

    localparam int MAX_LEN = 1024;
    localparam int VALUE_W = 30;
    localparam int CMD_W   = 2;
    localparam int SUM_W   = 42;
    localparam int OUT_W   = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_PREFIX_W,
        ST_CHAIN,
        ST_CHAIN_W,
        ST_SCAN,
        ST_SCAN_W,
        ST_HOP,
        ST_HOP_W,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_k;
        logic append;
        logic clear;
        logic pfx_start;
        logic pfx_step;
        logic chn_start;
        logic chn_step;
        logic scn_start;
        logic scn_step;
        logic hop_issue;
        logic hop_take;
        logic out_load;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic pfx_done;
        logic chn_done;
        logic scn_done;
        logic scn_newmin;
        logic hop_go;
    } sts_t;

endpackage

// File: rtl/core/lsmal_if.sv
// ----------------------------------------------------------------------------
// lsmal_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface lsmal_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lsmal_ctrl.sv
// ----------------------------------------------------------------------------
// lsmal_ctrl
// Sequencer for load, clear and the three query passes.
// ----------------------------------------------------------------------------
module lsmal_ctrl
    import lsmal_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic           in_ready,
    input  logic           out_free,
    input  sts_t           sts,
    output ctl_t           ctl
);

    state_t state_reg, state_next;
    logic   acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (acc && in_cmd == CMD_QUERY) state_next = ST_PREFIX;
            ST_PREFIX:   state_next = ST_PREFIX_W;
            ST_PREFIX_W: state_next = sts.pfx_done ? ST_CHAIN : ST_PREFIX_W;
            ST_CHAIN:    state_next = ST_CHAIN_W;
            ST_CHAIN_W:  state_next = sts.chn_done ? ST_SCAN : ST_CHAIN_W;
            ST_SCAN:     state_next = ST_SCAN_W;
            ST_SCAN_W:
            begin
                if (sts.scn_newmin)      state_next = ST_HOP;
                else if (sts.scn_done)   state_next = ST_OUT;
            end
            ST_HOP:      state_next = ST_HOP_W;
            ST_HOP_W:
            begin
                if (sts.hop_go)          state_next = ST_HOP;
                else if (sts.scn_done)   state_next = ST_OUT;
                else                     state_next = ST_SCAN_W;
            end
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.append = acc && in_cmd == CMD_APPEND;
                ctl.clear  = acc && in_cmd == CMD_CLEAR;
                ctl.load_k = acc && in_cmd == CMD_QUERY;
            end
            ST_PREFIX:   ctl.pfx_start = 1'b1;
            ST_PREFIX_W: ctl.pfx_step  = 1'b1;
            ST_CHAIN:    ctl.chn_start = 1'b1;
            ST_CHAIN_W:  ctl.chn_step  = 1'b1;
            ST_SCAN:     ctl.scn_start = 1'b1;
            ST_SCAN_W:   ctl.scn_step  = !sts.scn_newmin && !sts.scn_done;
            ST_HOP:      ctl.hop_issue = 1'b1;
            ST_HOP_W:    ctl.hop_take  = 1'b1;
            ST_OUT:      ctl.out_load = out_free;
            default:     ctl = '0;
        endcase
    end

endmodule

// File: rtl/core/lsmal_dp.sv
// ----------------------------------------------------------------------------
// lsmal_dp
// Element, prefix-sum and link memories with the pass counters.
// ----------------------------------------------------------------------------
module lsmal_dp
    import lsmal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  logic [VALUE_W-1:0] in_value,
    output sts_t               sts,
    output logic [OUT_W-1:0]   best
);

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int EW = $clog2(MAX_LEN);

    logic [VALUE_W-1:0]      elem_mem [MAX_LEN];
    logic signed [SUM_W-1:0] sum_mem  [MAX_LEN + 1];
    logic [AW:0]             link_mem [MAX_LEN + 1];   // {valid, index}

    logic [AW-1:0]           count_reg;
    logic [VALUE_W-1:0]      k_reg;
    logic [AW-1:0]           idx_reg;      // pass index
    logic                    phase_reg;    // read issued, data next cycle
    logic [VALUE_W-1:0]      elem_rd;
    logic signed [SUM_W-1:0] sum_rd;
    logic [AW:0]             link_rd;
    logic signed [SUM_W-1:0] acc_reg;      // running sum / max / min
    logic [AW-1:0]           cur_reg;
    logic                    have_reg;
    logic [OUT_W-1:0]        best_reg;
    logic [AW-1:0]           hop_reg;      // candidate link target
    logic                    newmin_reg;

    // read addresses
    logic [AW-1:0] sum_ra;
    logic [AW-1:0] link_ra;
    logic          sum_we;
    logic [AW-1:0] sum_wa;
    logic signed [SUM_W-1:0] sum_wd;
    logic          link_we;

    always_comb
    begin
        sum_ra  = idx_reg;
        link_ra = idx_reg;
        if (ctl.hop_issue)
        begin
            sum_ra  = hop_reg;
            link_ra = hop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.append && count_reg < AW'(MAX_LEN))
            elem_mem[count_reg[EW-1:0]] <= in_value;
        elem_rd <= elem_mem[idx_reg[EW-1:0]];
        if (sum_we)
            sum_mem[sum_wa] <= sum_wd;
        sum_rd <= sum_mem[sum_ra];
        if (link_we)
            link_mem[idx_reg] <= {have_reg, cur_reg};
        link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctl.clear)
            count_reg <= '0;
        else if (ctl.append && count_reg < AW'(MAX_LEN))
            count_reg <= count_reg + 1'b1;
    end

    logic signed [SUM_W-1:0] diff;
    assign diff = $signed({{(SUM_W-VALUE_W){1'b0}}, elem_rd})
                - $signed({{(SUM_W-VALUE_W){1'b0}}, k_reg});

    // hop target reached: keep following while the next link stays in range
    logic hop_more, hop_go;
    assign hop_more = link_rd[AW] && (link_rd[AW-1:0] <= count_reg);
    assign hop_go   = (sum_rd >= acc_reg) && hop_more;

    // prefix pass: read elem[idx], next cycle write sum[idx+1]
    always_comb
    begin
        sum_we = 1'b0;
        sum_wa = '0;
        sum_wd = '0;
        if (ctl.pfx_start)
        begin
            sum_we = 1'b1;
        end
        else if (ctl.pfx_step && phase_reg)
        begin
            sum_we = 1'b1;
            sum_wa = idx_reg + 1'b1;
            sum_wd = acc_reg + diff;
        end
    end

    assign link_we = ctl.chn_step && phase_reg;

    logic pfx_last, chn_last, scn_last;
    assign pfx_last = (count_reg == '0) || (phase_reg && idx_reg + 1'b1 == count_reg);
    assign chn_last = phase_reg && idx_reg == '0;
    assign scn_last = phase_reg && idx_reg == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= '0;
            acc_reg    <= '0;
            cur_reg    <= '0;
            hop_reg    <= '0;
            idx_reg    <= '0;
            phase_reg  <= 1'b0;
            have_reg   <= 1'b0;
            best_reg   <= '0;
            newmin_reg <= 1'b0;
        end
        else
        begin
            newmin_reg <= 1'b0;
            if (ctl.load_k)
                k_reg <= in_value;
            if (ctl.pfx_start)
            begin
                idx_reg   <= '0;
                phase_reg <= 1'b0;
                acc_reg   <= '0;
                best_reg  <= '0;
            end
            else if (ctl.pfx_step)
            begin
                if (!phase_reg)
                    phase_reg <= 1'b1;
                else
                begin
                    acc_reg <= sum_wd;
                    idx_reg <= idx_reg + 1'b1;
                    phase_reg <= 1'b0;
                end
            end
            if (ctl.chn_start)
            begin
                // the last entry has no link; point it at itself
                idx_reg   <= count_reg;
                cur_reg   <= count_reg;
                phase_reg <= 1'b0;
                have_reg  <= 1'b0;
            end
            else if (ctl.chn_step)
            begin
                if (!phase_reg)
                    phase_reg <= 1'b1;
                else
                begin
                    // link written this cycle with old cur/have
                    if (!have_reg || sum_rd > acc_reg)
                    begin
                        acc_reg  <= sum_rd;
                        cur_reg  <= idx_reg;
                        have_reg <= 1'b1;
                    end
                    if (idx_reg != '0)
                        idx_reg <= idx_reg - 1'b1;
                    phase_reg <= 1'b0;
                end
            end
            if (ctl.scn_start)
            begin
                idx_reg   <= '0;
                phase_reg <= 1'b0;
                have_reg  <= 1'b0;
            end
            else if (ctl.scn_step)
            begin
                if (!phase_reg)
                    phase_reg <= 1'b1;
                else
                begin
                    if (!have_reg || acc_reg > sum_rd)
                    begin
                        acc_reg    <= sum_rd;
                        have_reg   <= 1'b1;
                        cur_reg    <= idx_reg;
                        newmin_reg <= 1'b1;
                    end
                    else if (idx_reg != count_reg)
                        idx_reg <= idx_reg + 1'b1;
                    phase_reg <= (!have_reg || acc_reg > sum_rd);
                end
            end
            if (ctl.hop_issue)
            begin
                // hop_reg holds the link target; fetch its sum and link
            end
            if (ctl.hop_take)
            begin
                // after issue: sum_rd / link_rd refer to hop_reg
                if (sum_rd >= acc_reg)
                begin
                    cur_reg <= hop_reg;
                    hop_reg <= link_rd[AW-1:0];
                    if (!hop_more)
                    begin
                        if (hop_reg > idx_reg
                            && OUT_W'(hop_reg - idx_reg) > best_reg)
                            best_reg <= OUT_W'(hop_reg - idx_reg);
                        idx_reg   <= (idx_reg != count_reg) ? idx_reg + 1'b1 : idx_reg;
                        phase_reg <= 1'b0;
                    end
                end
                else
                begin
                    if (cur_reg > idx_reg
                        && OUT_W'(cur_reg - idx_reg) > best_reg)
                        best_reg <= OUT_W'(cur_reg - idx_reg);
                    idx_reg   <= (idx_reg != count_reg) ? idx_reg + 1'b1 : idx_reg;
                    phase_reg <= 1'b0;
                end
            end
            // new minimum found: read link of idx and seed the hop
            if (newmin_reg)
            begin
                hop_reg   <= link_rd[AW-1:0];
                phase_reg <= 1'b0;
            end
        end
    end

    // done at the last index of scan: flagged when that index is no new minimum, or when the final hop resolves
    logic scn_end_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scn_end_reg <= 1'b0;
        else if (ctl.scn_start)
            scn_end_reg <= 1'b0;
        else if ((ctl.scn_step && scn_last && !(!have_reg || acc_reg > sum_rd))
                 || (ctl.hop_take && idx_reg == count_reg && !hop_go))
            scn_end_reg <= 1'b1;
    end

    assign sts.pfx_done   = ctl.pfx_step && pfx_last;
    assign sts.chn_done   = ctl.chn_step && chn_last;
    assign sts.scn_done   = scn_end_reg;
    assign sts.scn_newmin = newmin_reg;
    assign sts.hop_go     = hop_go;
    assign best           = best_reg;

endmodule

// File: rtl/core/longest_segment_mean_at_least_top.sv
// ----------------------------------------------------------------------------
// longest_segment_mean_at_least_top
// Longest segment whose mean is at least a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel : cmd (append / query / clear) and a 30-bit value.
//   out channel : longest_length, one transaction per query.
//   Append, clear and the unused command produce no result; they can follow
//   each other with no gap.
//   A query runs three passes over its n stored entries through memories
//   with one read and one write port; each entry is read and then used:
//   prefix sums, suffix-maximum chain and the prefix-minimum scan, plus a
//   hop per new prefix minimum and per chain link checked. The input is
//   ready again when the result shows.
//   Reset empties the sequence; the element store is not cleared.
//   When the receiver stalls the result holds in the output register; the
//   input keeps taking transactions, but a following query holds its answer
//   until the register frees up.
// ----------------------------------------------------------------------------
module longest_segment_mean_at_least_top
    import lsmal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lsmal_if.sink   in_ch,
    lsmal_if.source out_ch
);

    ctl_t             ctl;
    sts_t             sts;
    logic [OUT_W-1:0] best;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    // controller: sequence the passes
    lsmal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.data[CMD_W+VALUE_W-1:VALUE_W]),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath: memories and pass arithmetic
    lsmal_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_value (in_ch.data[VALUE_W-1:0]),
        .sts      (sts),
        .best     (best)
    );

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
            out_data_reg <= best;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`ifndef SYNTHESIS
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped or changed while stalled");
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> out_ch.valid)
        else $error("result not presented");
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.append, ctl.clear, ctl.load_k}))
        else $error("overlapping commands");
`endif

endmodule

// File: tb/tb_longest_segment_mean_at_least_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_segment_mean_at_least_top
// Self-checking bench for the longest-segment-mean block. A queue-fed driver
// pushes append, query, clear and unused-command transactions. A monitor
// predicts each query answer from its own copy of the sequence. It compares
// each output transaction with the oldest expected length. The run has
// phases with different source-idle and sink-stall rates.
// ----------------------------------------------------------------------------
module tb_longest_segment_mean_at_least_top;
    import lsmal_pkg::*;

    localparam int MAXN    = MAX_LEN;
    localparam int IN_W    = CMD_W + VALUE_W;
    localparam int LIMIT   = 3000000;
    localparam logic [VALUE_W-1:0] VMAX = {VALUE_W{1'b1}};

    logic clk;
    logic rst_n;

    lsmal_if #(.W(IN_W))  in_ch ();
    lsmal_if #(.W(OUT_W)) out_ch ();

    longest_segment_mean_at_least_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Pending input transactions and expected query answers.
    logic [IN_W-1:0]  pending_q[$];
    logic [OUT_W-1:0] length_q[$];

    // Shadow of the block's sequence.
    logic [VALUE_W-1:0] seq_mem[MAXN];
    int                 seq_len;

    int  src_idle_pct;
    int  snk_stall_pct;
    int  mismatches;
    int  cycles;
    bit  done;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Longest run with mean >= k: prefix sums of (v - k), a right-to-left
    // chain of strict suffix maxima, then a walk from each new prefix minimum.
    function automatic logic [OUT_W-1:0] longest_mean(input logic [VALUE_W-1:0] k);
        longint ps[MAXN+1];
        int     nxt[MAXN+1];
        bit     nv[MAXN+1];
        int     n;
        int     cur;
        int     best;
        bit     have;
        longint mx;
        longint mn;
        n = seq_len;
        ps[0] = 0;
        for (int i = 0; i < n; i++)
            ps[i+1] = ps[i] + longint'(seq_mem[i]) - longint'(k);
        have = 0;
        cur  = 0;
        mx   = 0;
        for (int i = n; i >= 0; i--)
        begin
            nxt[i] = cur;
            nv[i]  = have;
            if (!have || ps[i] > mx)
            begin
                mx   = ps[i];
                cur  = i;
                have = 1;
            end
        end
        have = 0;
        mn   = 0;
        best = 0;
        for (int i = 0; i <= n; i++)
        begin
            if (!have || mn > ps[i])
            begin
                mn   = ps[i];
                have = 1;
                cur  = i;
                while (nv[cur] && nxt[cur] <= n && ps[nxt[cur]] >= mn)
                    cur = nxt[cur];
                if (cur > i && cur - i > best)
                    best = cur - i;
            end
        end
        return best[OUT_W-1:0];
    endfunction

    // Driver: hold the transaction until accepted, then advance or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Sink: stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge clk)
    begin
        logic [CMD_W-1:0]   c;
        logic [VALUE_W-1:0] v;
        logic [OUT_W-1:0]   exp_len;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                {c, v} = in_ch.data;
                case (cmd_t'(c))
                    CMD_APPEND:
                        if (seq_len < MAXN)
                        begin
                            seq_mem[seq_len] = v;
                            seq_len++;
                        end
                    CMD_QUERY: length_q.push_back(longest_mean(v));
                    CMD_CLEAR: seq_len = 0;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (length_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: longest_length=%0d", out_ch.data);
                end
                else
                begin
                    exp_len = length_q.pop_front();
                    if (out_ch.data !== exp_len)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("longest_length mismatch: expected %0d got %0d",
                                     exp_len, out_ch.data);
                    end
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT && !done)
        begin
            $display("longest_segment_mean_at_least_top test failed");
            $finish;
        end
    end

    // Pack a transaction; the value keeps its low VALUE_W bits.
    function automatic logic [IN_W-1:0] txn(input cmd_t c, input logic [31:0] v);
        return {c, v[VALUE_W-1:0]};
    endfunction

    // Value near k, clamped to the field range.
    function automatic logic [VALUE_W-1:0] near(input logic [VALUE_W-1:0] k, input int spread);
        longint x;
        x = longint'(k) + longint'($urandom_range(2*spread)) - longint'(spread);
        if (x < 0)
            x = 0;
        if (x > longint'(VMAX))
            x = longint'(VMAX);
        return x[VALUE_W-1:0];
    endfunction

    // Wait until the block has drained everything queued so far.
    task automatic drain();
        wait (pending_q.size() == 0 && length_q.size() == 0);
        @(posedge clk);
        while (in_ch.valid || length_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_sequences(input int items);
        logic [VALUE_W-1:0] k;
        int                 n;
        int                 spread;
        int                 sent;
        sent = 0;
        while (sent < items)
        begin
            pending_q.push_back(txn(CMD_CLEAR, $urandom));
            k      = VALUE_W'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom);
            spread = ($urandom_range(1) == 0) ? 4 : 1 << $urandom_range(28);
            n      = $urandom_range(16);
            for (int i = 0; i < n; i++)
            begin
                // drop in an occasional no-op or wild value
                if ($urandom_range(15) == 0)
                    pending_q.push_back(txn(CMD_NONE, $urandom));
                pending_q.push_back(txn(CMD_APPEND,
                    ($urandom_range(9) == 0) ? $urandom : 32'(near(k, spread))));
            end
            for (int q = $urandom_range(1, 3); q > 0; q--)
                pending_q.push_back(txn(CMD_QUERY, 32'(near(k, spread))));
            sent += n + 3;
        end
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        seq_len       = 0;
        mismatches    = 0;
        cycles        = 0;
        done          = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rst_n         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty query, extremes, no-op command, clear.
        pending_q.push_back(txn(CMD_QUERY, 0));
        pending_q.push_back(txn(CMD_APPEND, 0));
        pending_q.push_back(txn(CMD_APPEND, 32'(VMAX)));
        pending_q.push_back(txn(CMD_QUERY, 0));
        pending_q.push_back(txn(CMD_QUERY, 32'(VMAX)));
        pending_q.push_back(txn(CMD_QUERY, 32'(VMAX >> 1)));
        pending_q.push_back(txn(CMD_NONE, 32'(VMAX)));
        pending_q.push_back(txn(CMD_APPEND, 5));
        pending_q.push_back(txn(CMD_APPEND, 1));
        pending_q.push_back(txn(CMD_APPEND, 9));
        pending_q.push_back(txn(CMD_QUERY, 5));
        pending_q.push_back(txn(CMD_QUERY, 10));
        pending_q.push_back(txn(CMD_CLEAR, 32'(VMAX)));
        pending_q.push_back(txn(CMD_QUERY, 0));
        pending_q.push_back(txn(CMD_APPEND, 7));
        pending_q.push_back(txn(CMD_QUERY, 7));
        pending_q.push_back(txn(CMD_QUERY, 8));
        drain();

        // Random phases; each drain is a full pause of the source.
        random_sequences(30);
        drain();
        src_idle_pct = 69;
        random_sequences(30);
        drain();
        src_idle_pct  = 0;
        snk_stall_pct = 69;
        random_sequences(30);
        drain();
        src_idle_pct = 6;
        snk_stall_pct = 6;
        random_sequences(30);
        drain();

        repeat (50) @(posedge clk);
        done = 1;
        if (mismatches == 0 && length_q.size() == 0)
            $display("longest_segment_mean_at_least_top test passed");
        else
            $display("longest_segment_mean_at_least_top test failed");
        $finish;
    end
endmodule
